// File: design/rpn_pkg.sv
// shared types and constants for the postfix expression evaluator
package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int RESULT_WIDTH    = 32;
  localparam int CHAR_WIDTH      = 8;

  localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_WIDTH-1:0] CH_STAR  = 8'h2a;
  localparam logic [CHAR_WIDTH-1:0] CH_SLASH = 8'h2f;
  localparam logic [CHAR_WIDTH-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_WIDTH-1:0] CH_EQ    = 8'h3d;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5,
    OP_EQ   = 3'd6,
    OP_BAD  = 3'd7
  } op_t;

  typedef struct packed {
    logic has_num;
    op_t  op;
    logic last;
  } tok_ctl_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] character;
    logic                  last;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_WIDTH-1:0] value;
    status_t                        status;
  } out_item_t;

endpackage

// File: design/rpn_ram.sv
// generic single-port-write ram with registered read
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/rpn_fifo.sv
// small register queue between the front and back parts
module rpn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

endmodule

// File: design/rpn_front.sv
// front part: character classification and number accumulation into tokens
module rpn_front #(
  parameter int VALUE_WIDTH = rpn_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  rpn_pkg::in_item_t      in_data,
  output logic                   tok_push,
  input  logic                   tok_full,
  output rpn_pkg::tok_ctl_t      tok_ctl,
  output logic [VALUE_WIDTH-1:0] tok_num
);

  import rpn_pkg::*;

  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt, acc_step;
  logic                   innum_r, innum_nxt;
  logic                   accept;
  logic                   is_digit;
  logic [CHAR_WIDTH-1:0]  digit;
  op_t                    op_code;

  assign full     = tok_full;
  assign accept   = push & ~full;
  assign is_digit = (in_data.character >= CH_ZERO) && (in_data.character <= CH_NINE);
  assign digit    = in_data.character - CH_ZERO;
  // times ten as two shifts
  assign acc_step = (acc_r << 3) + (acc_r << 1) + VALUE_WIDTH'(digit);

  always_comb begin
    unique case (in_data.character)
      CH_PLUS:  op_code = OP_ADD;
      CH_MINUS: op_code = OP_SUB;
      CH_STAR:  op_code = OP_MUL;
      CH_SLASH: op_code = OP_DIV;
      CH_PCT:   op_code = OP_MOD;
      CH_EQ:    op_code = OP_EQ;
      CH_SPACE: op_code = OP_NONE;
      default:  op_code = OP_BAD;
    endcase
  end

  always_comb begin
    acc_nxt   = acc_r;
    innum_nxt = innum_r;
    tok_push  = 1'b0;
    tok_ctl   = '{has_num: innum_r, op: op_code, last: in_data.last};
    tok_num   = acc_r;
    if (accept) begin
      if (is_digit) begin
        acc_nxt         = acc_step;
        innum_nxt       = 1'b1;
        tok_ctl.has_num = 1'b1;
        tok_ctl.op      = OP_NONE;
        tok_num         = acc_step;
        tok_push        = in_data.last;
      end else begin
        acc_nxt   = '0;
        innum_nxt = 1'b0;
        tok_push  = innum_r | (op_code != OP_NONE) | in_data.last;
      end
      if (in_data.last) begin
        acc_nxt   = '0;
        innum_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      innum_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      innum_r <= innum_nxt;
    end
  end

endmodule

// File: design/rpn_back.sv
// back part: operand stack sequencer, shared multiply/divide unit and result register
module rpn_back #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = rpn_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   tok_empty,
  output logic                   tok_pop,
  input  rpn_pkg::tok_ctl_t      tok_ctl,
  input  logic [VALUE_WIDTH-1:0] tok_num,
  output logic                   empty,
  input  logic                   pop,
  output rpn_pkg::out_item_t     out_data
);

  import rpn_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = $clog2(W + 1);
  localparam int XW = (W > RESULT_WIDTH) ? W : RESULT_WIDTH;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_WAITB = 10'b0000000100,
    S_WAITA = 10'b0000001000,
    S_OP    = 10'b0000010000,
    S_MUL   = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_POPT  = 10'b0010000000,
    S_WAITT = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  function automatic status_t flag_err(status_t cur, status_t code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  function automatic state_t next_after(logic last, logic fin);
    return last ? (fin ? S_EMIT : S_POPT) : S_IDLE;
  endfunction

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt, cnt_dec;
  status_t         err_r, err_nxt;
  logic            fin_r, fin_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [W-1:0]    fval_r, fval_nxt;
  tok_ctl_t        tok_r, tok_nxt;
  logic [W-1:0]    a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic [W-1:0]    wq_r, wq_nxt, wd_r, wd_nxt;
  logic [W-1:0]    wr_r, wr_nxt;
  logic [SW-1:0]   step_r, step_nxt;
  logic            negq_r, negq_nxt, negr_r, negr_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic            push_req;
  logic [W-1:0]    push_val;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [W-1:0]    rdata;
  logic [W:0]      div_sh, div_diff;
  logic [W-1:0]    quo_val, rem_val, emit_val;
  logic signed [XW-1:0] ext_val;

  rpn_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (push_val),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cnt_dec  = cnt_r - 1'b1;
  assign raddr    = cnt_dec[AW-1:0];
  assign waddr    = cnt_r[AW-1:0];
  assign div_sh   = {wr_r, wq_r[W-1]};
  assign div_diff = div_sh - {1'b0, wd_r};
  assign quo_val  = negq_r ? (~wq_r + 1'b1) : wq_r;
  assign rem_val  = negr_r ? (~wr_r + 1'b1) : wr_r;
  assign emit_val = fin_r ? fval_r : res_r;
  assign ext_val  = XW'(signed'(emit_val));
  assign empty    = ~out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    fin_nxt       = fin_r;
    fval_nxt      = fval_r;
    tok_nxt       = tok_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    wq_nxt        = wq_r;
    wd_nxt        = wd_r;
    wr_nxt        = wr_r;
    step_nxt      = step_r;
    negq_nxt      = negq_r;
    negr_nxt      = negr_r;
    out_valid_nxt = out_valid_r & ~pop;
    out_data_nxt  = out_data_r;
    tok_pop       = 1'b0;
    push_req      = 1'b0;
    push_val      = res_r;
    we            = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!tok_empty) begin
          tok_pop = 1'b1;
          tok_nxt = tok_ctl;
          if (!fin_r && tok_ctl.has_num) begin
            push_req = 1'b1;
            push_val = tok_num;
          end
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (fin_r || tok_r.op == OP_NONE) begin
          state_nxt = next_after(tok_r.last, fin_r);
        end else if (cnt_r != '0) begin
          cnt_nxt   = cnt_dec;
          state_nxt = S_WAITB;
        end else begin
          err_nxt   = flag_err(err_r, ST_UNDER);
          a_nxt     = '0;
          b_nxt     = '0;
          state_nxt = S_OP;
        end
      end
      S_WAITB: begin
        b_nxt = rdata;
        if (cnt_r != '0) begin
          cnt_nxt   = cnt_dec;
          state_nxt = S_WAITA;
        end else begin
          err_nxt   = flag_err(err_r, ST_UNDER);
          a_nxt     = '0;
          state_nxt = S_OP;
        end
      end
      S_WAITA: begin
        a_nxt     = rdata;
        state_nxt = S_OP;
      end
      S_OP: begin
        state_nxt = next_after(tok_r.last, fin_r);
        unique case (tok_r.op)
          OP_ADD: begin
            push_req = 1'b1;
            push_val = a_r + b_r;
          end
          OP_SUB: begin
            push_req = 1'b1;
            push_val = a_r - b_r;
          end
          OP_MUL: begin
            wd_nxt    = a_r;
            wq_nxt    = b_r;
            res_nxt   = '0;
            state_nxt = S_MUL;
          end
          OP_DIV, OP_MOD: begin
            if (b_r == '0) begin
              err_nxt  = flag_err(err_r, ST_DIVZERO);
              push_req = 1'b1;
              push_val = '0;
            end else begin
              negq_nxt  = a_r[W-1] ^ b_r[W-1];
              negr_nxt  = a_r[W-1];
              wq_nxt    = a_r[W-1] ? (~a_r + 1'b1) : a_r;
              wd_nxt    = b_r[W-1] ? (~b_r + 1'b1) : b_r;
              wr_nxt    = '0;
              step_nxt  = '0;
              state_nxt = S_DIV;
            end
          end
          OP_EQ: begin
            fin_nxt   = 1'b1;
            fval_nxt  = b_r;
            state_nxt = next_after(tok_r.last, 1'b1);
          end
          default: begin
            state_nxt = next_after(tok_r.last, fin_r);
          end
        endcase
      end
      S_MUL: begin
        if (wq_r == '0) begin
          push_req  = 1'b1;
          push_val  = res_r;
          state_nxt = next_after(tok_r.last, fin_r);
        end else begin
          if (wq_r[0]) begin
            res_nxt = res_r + wd_r;
          end
          wd_nxt = wd_r << 1;
          wq_nxt = wq_r >> 1;
        end
      end
      S_DIV: begin
        if (step_r == SW'(W)) begin
          push_req  = 1'b1;
          push_val  = (tok_r.op == OP_MOD) ? rem_val : quo_val;
          state_nxt = next_after(tok_r.last, fin_r);
        end else begin
          if (!div_diff[W]) begin
            wr_nxt = div_diff[W-1:0];
            wq_nxt = {wq_r[W-2:0], 1'b1};
          end else begin
            wr_nxt = div_sh[W-1:0];
            wq_nxt = {wq_r[W-2:0], 1'b0};
          end
          step_nxt = step_r + 1'b1;
        end
      end
      S_POPT: begin
        if (cnt_r != '0) begin
          cnt_nxt   = cnt_dec;
          state_nxt = S_WAITT;
        end else begin
          err_nxt   = flag_err(err_r, ST_UNDER);
          res_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_WAITT: begin
        res_nxt   = rdata;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || pop) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.value  = ext_val[RESULT_WIDTH-1:0];
          out_data_nxt.status = err_r;
          cnt_nxt             = '0;
          err_nxt             = ST_OK;
          fin_nxt             = 1'b0;
          fval_nxt            = '0;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (push_req) begin
      if (cnt_r < CW'(STACK_DEPTH)) begin
        we      = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        err_nxt = flag_err(err_nxt, ST_OVER);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ST_OK;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fval_r     <= fval_nxt;
    tok_r      <= tok_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    res_r      <= res_nxt;
    wq_r       <= wq_nxt;
    wd_r       <= wd_nxt;
    wr_r       <= wr_nxt;
    step_r     <= step_nxt;
    negq_r     <= negq_nxt;
    negr_r     <= negr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: design/postfix_expression_evaluator.sv
// top level of the postfix expression evaluator
// only token-ending characters reach the back part through the token queue
// the back part multiplies by shift and add, one step per bit up to the top set bit of
// the multiplier, and divides for / and % by restoring steps over VALUE_WIDTH bits,
// skipped on a zero divisor; the result and its status are held in the output register
// until popped; synchronous active-low reset clears control state, not the ram
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = rpn_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  rpn_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output rpn_pkg::out_item_t out_data
);

  import rpn_pkg::*;

  localparam int CTL_WIDTH = $bits(tok_ctl_t);
  localparam int TOK_WIDTH = CTL_WIDTH + VALUE_WIDTH;

  logic                   q_push, q_full, q_pop, q_empty;
  tok_ctl_t               f_ctl, q_ctl;
  logic [VALUE_WIDTH-1:0] f_num, q_num;
  logic [TOK_WIDTH-1:0]   q_wdata, q_rdata;

  rpn_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .tok_push (q_push),
    .tok_full (q_full),
    .tok_ctl  (f_ctl),
    .tok_num  (f_num)
  );

  assign q_wdata = {f_ctl, f_num};

  rpn_fifo #(
    .WIDTH (TOK_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  assign q_ctl = tok_ctl_t'(q_rdata[TOK_WIDTH-1:VALUE_WIDTH]);
  assign q_num = q_rdata[VALUE_WIDTH-1:0];

  rpn_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_empty (q_empty),
    .tok_pop   (q_pop),
    .tok_ctl   (q_ctl),
    .tok_num   (q_num),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("token written into a full queue");

  a_queue_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("token taken from an empty queue");

  a_last_token: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && in_data.last) |=> !q_empty)
    else $error("final character did not produce a queued token");

endmodule
